// File: hw/rtl/disc_header_product_id_scanner_macros.svh
// Assertion macros for the boot-header product-id scanner.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef DISC_HEADER_PRODUCT_ID_SCANNER_MACROS_SVH
`define DISC_HEADER_PRODUCT_ID_SCANNER_MACROS_SVH

// same-cycle implication
`define DHPS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DHPS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/dhps_pkg.sv
// Shared constants, types and the header magic lookup for the product-id scanner.
// No dependencies.
package dhps_pkg;

  localparam int SECTOR_BYTES = 2048;
  localparam int POS_W        = $clog2(SECTOR_BYTES);
  localparam int MAGIC_LEN    = 15;
  localparam int PROD_OFF     = 'h40;
  localparam int PROD_LEN     = 10;

  localparam logic [15:0] MAX_SECTORS_RESET = 16'd20000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] product_low;
    logic [15:0] product_high;
    logic [3:0]  product_length;
    logic [15:0] header_sector;
  } result_t;

  // boot-header magic, one byte per offset
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h45;
      4'd2:    c = 8'h47;
      4'd3:    c = 8'h41;
      4'd4:    c = 8'h20;
      4'd5:    c = 8'h53;
      4'd6:    c = 8'h45;
      4'd7:    c = 8'h47;
      4'd8:    c = 8'h41;
      4'd9:    c = 8'h4B;
      4'd10:   c = 8'h41;
      4'd11:   c = 8'h54;
      4'd12:   c = 8'h41;
      4'd13:   c = 8'h4E;
      4'd14:   c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/dhps_validate.sv
// Product string check: trim, cut at NUL, printable and alphanumeric tests.
// Depends on dhps_pkg.
module dhps_validate (
  input  logic [dhps_pkg::PROD_LEN*8-1:0] product,
  input  logic [15:0]                     sector,
  output dhps_pkg::result_t               result
);

  logic [7:0] ch [dhps_pkg::PROD_LEN];
  logic [3:0] len_trim;
  logic [3:0] len;
  logic       printable;
  logic       has_an;
  logic [dhps_pkg::PROD_LEN*8-1:0] masked;

  always_comb begin
    for (int i = 0; i < dhps_pkg::PROD_LEN; i++) begin
      ch[i] = product[i*8 +: 8];
    end

    // length after dropping trailing whitespace
    len_trim = 4'd0;
    for (int i = 0; i < dhps_pkg::PROD_LEN; i++) begin
      if (!(ch[i] == dhps_pkg::CH_SPACE ||
            (ch[i] >= dhps_pkg::CH_TAB && ch[i] <= dhps_pkg::CH_CR))) begin
        len_trim = 4'(i + 1);
      end
    end

    // first NUL inside the trimmed string wins
    len = len_trim;
    for (int i = dhps_pkg::PROD_LEN - 1; i >= 0; i--) begin
      if (4'(i) < len_trim && ch[i] == dhps_pkg::CH_NUL) begin
        len = 4'(i);
      end
    end

    printable = 1'b1;
    has_an    = 1'b0;
    masked    = '0;
    for (int i = 0; i < dhps_pkg::PROD_LEN; i++) begin
      if (4'(i) < len) begin
        masked[i*8 +: 8] = ch[i];
        if (ch[i] < dhps_pkg::CH_SPACE || ch[i] > dhps_pkg::CH_TILDE) begin
          printable = 1'b0;
        end
        if ((ch[i] >= dhps_pkg::CH_A && ch[i] <= dhps_pkg::CH_Z) ||
            (ch[i] >= dhps_pkg::CH_0 && ch[i] <= dhps_pkg::CH_9)) begin
          has_an = 1'b1;
        end
      end
    end

    result.header_sector = sector;
    if (len != 4'd0 && printable && has_an) begin
      result.status         = dhps_pkg::ST_FOUND;
      result.product_low    = masked[63:0];
      result.product_high   = masked[79:64];
      result.product_length = len;
    end else begin
      result.status         = dhps_pkg::ST_INVALID;
      result.product_low    = '0;
      result.product_high   = '0;
      result.product_length = '0;
    end
  end

endmodule

// File: hw/rtl/dhps_scan.sv
// Sector byte counter, magic compare, product capture and result decision.
// Depends on dhps_pkg and dhps_validate.
module dhps_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,         // registered beat is consumed
  input  logic [7:0]          data_byte,
  input  logic                end_of_image,
  input  logic [15:0]         max_sectors,
  output logic                emit,         // the current beat yields a result
  output dhps_pkg::result_t   result
);

  localparam int PW = dhps_pkg::POS_W;

  logic [PW-1:0] byte_in_sector, byte_in_sector_next;
  logic [15:0]   sector_index, sector_index_next;
  logic          magic_still_matching, magic_still_matching_next;
  logic          result_given, result_given_next;
  logic [7:0]    product_bytes [dhps_pkg::PROD_LEN];
  logic [dhps_pkg::PROD_LEN*8-1:0] product_flat;

  logic          in_magic, in_prod, sector_end, match_now, limit_hit;
  logic [3:0]    prod_idx;
  logic [15:0]   limit;
  logic [16:0]   sector_inc;
  dhps_pkg::result_t valid_res;

  always_comb begin
    for (int i = 0; i < dhps_pkg::PROD_LEN; i++) begin
      product_flat[i*8 +: 8] = product_bytes[i];
    end
  end

  dhps_validate u_validate (
    .product (product_flat),
    .sector  (sector_index),
    .result  (valid_res)
  );

  assign in_magic   = byte_in_sector < PW'(dhps_pkg::MAGIC_LEN);
  assign in_prod    = byte_in_sector >= PW'(dhps_pkg::PROD_OFF) &&
                      byte_in_sector < PW'(dhps_pkg::PROD_OFF + dhps_pkg::PROD_LEN);
  assign prod_idx   = 4'(byte_in_sector - PW'(dhps_pkg::PROD_OFF));
  assign sector_end = byte_in_sector == PW'(dhps_pkg::SECTOR_BYTES - 1);
  assign match_now  = magic_still_matching &&
                      !(in_magic && data_byte != dhps_pkg::magic_byte(byte_in_sector[3:0]));
  assign limit      = (max_sectors == 16'd0) ? 16'd1 : max_sectors;
  assign sector_inc = {1'b0, sector_index} + 17'd1;
  assign limit_hit  = sector_inc >= {1'b0, limit};

  always_comb begin
    byte_in_sector_next       = byte_in_sector;
    sector_index_next         = sector_index;
    magic_still_matching_next = magic_still_matching;
    result_given_next         = result_given;
    emit                      = 1'b0;
    result                    = valid_res;

    if (!result_given) begin
      if (sector_end) begin
        byte_in_sector_next       = '0;
        magic_still_matching_next = 1'b1;
        if (match_now) begin
          emit              = 1'b1;
          result_given_next = 1'b1;
        end else if (limit_hit) begin
          emit              = 1'b1;
          result_given_next = 1'b1;
        end else begin
          sector_index_next = sector_inc[15:0];
        end
      end else begin
        byte_in_sector_next       = byte_in_sector + PW'(1);
        magic_still_matching_next = match_now;
      end
    end

    // not-found unless the header sector itself produced a result
    if (!(sector_end && match_now && !result_given)) begin
      result.status         = dhps_pkg::ST_NOT_FOUND;
      result.product_low    = '0;
      result.product_high   = '0;
      result.product_length = '0;
      result.header_sector  = '0;
    end

    if (end_of_image) begin
      if (!result_given_next) begin
        emit = 1'b1;
      end
      byte_in_sector_next       = '0;
      sector_index_next         = '0;
      magic_still_matching_next = 1'b1;
      result_given_next         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_sector       <= '0;
      sector_index         <= '0;
      magic_still_matching <= 1'b1;
      result_given         <= 1'b0;
    end else if (step) begin
      byte_in_sector       <= byte_in_sector_next;
      sector_index         <= sector_index_next;
      magic_still_matching <= magic_still_matching_next;
      result_given         <= result_given_next;
    end
  end

  // product capture; entries are always written before a sector can end
  always_ff @(posedge clk) begin
    if (step && !result_given && in_prod) begin
      product_bytes[prod_idx] <= data_byte;
    end
  end

endmodule

// File: hw/rtl/disc_header_product_id_scanner.sv
// Top level of the boot-header product-id scanner: input beat register,
// scan core, result register and the max_sectors register. Depends on dhps_pkg,
// dhps_scan and the assertion macro header.
//
//  port group  dir  payload
//  s_axis      in   tdata[7:0] data_byte, tlast end_of_image
//  m_axis      out  tdata: product_low, product_high, product_length,
//                   header_sector; tuser status
//  cfg         in   cfg_data max_sectors, written when cfg_we is high
//
// One byte per cycle sustained, save for the wait below; a byte stays in the
// input register until consumed, and its result loads at the edge it leaves.
// Bytes that yield no result keep flowing while a result waits on m_axis.
// A byte that yields a result waits only while the result register is full
// and m_axis_tready is low.
// Synchronous reset clears all control state and sets max_sectors to 20000.
`include "disc_header_product_id_scanner_macros.svh"

module disc_header_product_id_scanner (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_image
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // [63:0] product_low, [79:64] product_high,
                                       // [83:80] product_length,
                                       // [99:84] header_sector, [103:100] zero
  output logic [1:0]   m_axis_tuser,   // [1:0] status
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data        // max_sectors
);

  logic [15:0] max_sectors;

  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_last;
  logic        a_step;
  logic        r_free;

  logic              emit;
  dhps_pkg::result_t scan_res;
  dhps_pkg::result_t r_res;
  logic              r_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sectors <= dhps_pkg::MAX_SECTORS_RESET;
    end else if (cfg_we) begin
      max_sectors <= cfg_data;
    end
  end

  assign r_free        = !r_valid || m_axis_tready;
  assign a_step        = a_valid && (!emit || r_free);
  assign s_axis_tready = !a_valid || a_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_byte <= s_axis_tdata;
      a_last <= s_axis_tlast;
    end
  end

  dhps_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (a_step),
    .data_byte    (a_byte),
    .end_of_image (a_last),
    .max_sectors  (max_sectors),
    .emit         (emit),
    .result       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (a_step && emit) begin
      r_valid <= 1'b1;
    end else if (m_axis_tready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_step && emit) begin
      r_res <= scan_res;
    end
  end

  assign m_axis_tvalid = r_valid;
  assign m_axis_tuser  = r_res.status;
  assign m_axis_tdata  = {4'd0, r_res.header_sector, r_res.product_length,
                          r_res.product_high, r_res.product_low};

  `DHPS_ASSERT_NOW(a_found_has_length,
    r_valid && r_res.status == dhps_pkg::ST_FOUND, r_res.product_length != 4'd0,
    "found result with empty product")
  `DHPS_ASSERT_NOW(a_not_found_clean,
    r_valid && r_res.status == dhps_pkg::ST_NOT_FOUND,
    r_res.header_sector == 16'd0 && r_res.product_length == 4'd0,
    "not-found result carries header data")
  `DHPS_ASSERT_NEXT(a_emit_lands,
    a_step && emit, r_valid,
    "emitted result did not reach the output register")

endmodule

// File: verif/disc_header_scan_checker.sv
// Scoreboard for the boot-header product-id scanner: follows accepted bytes and
// max_sectors writes, predicts each scan report and compares it on m_axis.
// Depends on dhps_pkg for the result layout, status codes and constants.
module disc_header_scan_checker
  import dhps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [103:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,
  output int           reports_pending,
  output int           fail_count
);

  // boot-header magic, byte 0 in the low bits
  localparam logic [8*MAGIC_LEN-1:0] HDR_MAGIC = 120'h414E4154414B414745532041474553;

  logic [15:0] sector_limit;
  int          byte_pos;
  logic [15:0] sector_no;
  bit          magic_ok;
  logic [7:0]  prod_buf [PROD_LEN];
  bit          reported;
  result_t     scan_reports [$];
  int          errors = 0;

  assign fail_count = errors;

  function automatic void restart_scan();
    byte_pos  = 0;
    sector_no = '0;
    magic_ok  = 1'b1;
    reported  = 1'b0;
    for (int i = 0; i < PROD_LEN; i++) prod_buf[i] = CH_NUL;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic result_t miss_report();
    result_t r;
    r = '0;
    r.status = ST_NOT_FOUND;
    return r;
  endfunction

  // trim trailing blanks, cut at the first NUL, then require printable text
  // with at least one uppercase letter or digit
  function automatic result_t judge_product();
    result_t r;
    int      len;
    int      i;
    bit      clean;
    bit      named;
    r = '0;
    r.status = ST_INVALID;
    r.header_sector = sector_no;
    len = PROD_LEN;
    while (len > 0 && is_blank(prod_buf[len-1])) len--;
    for (i = 0; i < len; i++) begin
      if (prod_buf[i] == CH_NUL) begin
        len = i;
        break;
      end
    end
    clean = (len > 0);
    named = 1'b0;
    for (i = 0; i < len; i++) begin
      if (prod_buf[i] < CH_SPACE || prod_buf[i] > CH_TILDE) clean = 1'b0;
      if ((prod_buf[i] >= CH_A && prod_buf[i] <= CH_Z) ||
          (prod_buf[i] >= CH_0 && prod_buf[i] <= CH_9)) named = 1'b1;
    end
    if (clean && named) begin
      r.status = ST_FOUND;
      r.product_length = len[3:0];
      for (i = 0; i < len; i++) begin
        if (i < 8) r.product_low[8*i +: 8] = prod_buf[i];
        else r.product_high[8*(i-8) +: 8] = prod_buf[i];
      end
    end
    return r;
  endfunction

  function automatic void scan_byte(logic [7:0] b, logic last);
    int lim;
    if (!reported) begin
      if (byte_pos < MAGIC_LEN && b != HDR_MAGIC[8*byte_pos +: 8]) magic_ok = 1'b0;
      if (byte_pos >= PROD_OFF && byte_pos < PROD_OFF + PROD_LEN)
        prod_buf[byte_pos - PROD_OFF] = b;
      byte_pos++;
      if (byte_pos >= SECTOR_BYTES) begin
        byte_pos = 0;
        lim = (sector_limit == 16'd0) ? 1 : int'(sector_limit);
        if (magic_ok) begin
          scan_reports.push_back(judge_product());
          reported = 1'b1;
        end else if (int'(sector_no) + 1 >= lim) begin
          scan_reports.push_back(miss_report());
          reported = 1'b1;
        end else begin
          sector_no++;
        end
        magic_ok = 1'b1;
      end
    end
    // end of image: report not-found if nothing went out, then start over
    if (last) begin
      if (!reported) scan_reports.push_back(miss_report());
      restart_scan();
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      restart_scan();
      sector_limit = MAX_SECTORS_RESET;
      scan_reports.delete();
    end else begin
      if (cfg_we) sector_limit = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (scan_reports.size() == 0) begin
          $display("%0t: report with nothing expected, status %0d", $time, m_axis_tuser);
          errors++;
        end else begin
          want = scan_reports.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("product_low", want.product_low, m_axis_tdata[63:0]);
          check_field("product_high", want.product_high, m_axis_tdata[79:64]);
          check_field("product_length", want.product_length, m_axis_tdata[83:80]);
          check_field("header_sector", want.header_sector, m_axis_tdata[99:84]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata, s_axis_tlast);
    end
    reports_pending <= scan_reports.size();
  end

endmodule

// File: verif/tb_disc_header_product_id_scanner.sv
// Top of the product-id scanner testbench: clock, reset, image byte stimulus,
// max_sectors writes and the verdict. Depends on dhps_pkg, the scanner and
// disc_header_scan_checker.
module tb_disc_header_product_id_scanner;
  import dhps_pkg::*;

  typedef enum int {
    NM_PLAIN, NM_TRAIL_BLANK, NM_MID_NUL, NM_ALL_BLANK, NM_CONTROL, NM_LOWER,
    NM_NOISE, NM_LEAD_NUL, NM_DIGITS, NM_NUL_THEN_BLANK, NM_EDGES
  } name_kind_e;

  typedef enum int {IMG_SHORT, IMG_HEADER, IMG_PARTIAL, IMG_NO_HEADER} image_shape_e;

  // magic handling of put_sector
  localparam int HDR_OK      = -1;
  localparam int NOISE_MAGIC = 99;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'h00;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we        = 1'b0;
  logic [15:0]  cfg_data      = 16'd0;

  int         reports_pending;
  int         fail_count;
  bit         tx_steady  = 1'b0;
  bit         rx_steady  = 1'b0;
  int         stall_asks = 0;
  int         stall_done = 0;
  logic [7:0] name_buf [PROD_LEN];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  disc_header_product_id_scanner DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  disc_header_scan_checker scan_chk (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .reports_pending (reports_pending),
    .fail_count      (fail_count)
  );

  // result side: random backpressure, always ready while rx_steady is set, or a long hold-off when asked
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0 && stall_asks != stall_done) begin
        stall_done++;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  function automatic logic [7:0] blank_char();
    int pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
  endfunction

  // one beat; tready is sampled at the falling edge, clear of the driving edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit took;
    if (!tx_steady && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  task automatic make_product(input name_kind_e kind);
    int cut;
    int i;
    for (i = 0; i < PROD_LEN; i++) name_buf[i] = CH_SPACE + 8'($urandom_range(0, 94));
    name_buf[$urandom_range(0, PROD_LEN - 1)] = CH_A + 8'($urandom_range(0, 25));
    cut = $urandom_range(1, PROD_LEN - 1);
    case (kind)
      NM_TRAIL_BLANK: for (i = cut; i < PROD_LEN; i++) name_buf[i] = blank_char();
      NM_MID_NUL:     name_buf[cut] = CH_NUL;
      NM_ALL_BLANK:   for (i = 0; i < PROD_LEN; i++) name_buf[i] = blank_char();
      NM_CONTROL: begin
        name_buf[$urandom_range(0, PROD_LEN - 1)] = $urandom_range(0, 1) ?
            8'($urandom_range(8'h7F, 8'hFF)) : 8'($urandom_range(1, 8'h1F));
      end
      NM_LOWER: begin
        // lowercase and tilde only: printable but nothing that names a product
        for (i = 0; i < PROD_LEN; i++)
          name_buf[i] = ($urandom_range(0, 3) == 0) ? CH_TILDE : 8'h61 + 8'($urandom_range(0, 25));
      end
      NM_NOISE:    for (i = 0; i < PROD_LEN; i++) name_buf[i] = 8'($urandom_range(0, 255));
      NM_LEAD_NUL: name_buf[0] = CH_NUL;
      NM_DIGITS:   for (i = 0; i < PROD_LEN; i++) name_buf[i] = CH_0 + 8'($urandom_range(0, 9));
      NM_NUL_THEN_BLANK: begin
        name_buf[cut] = CH_NUL;
        for (i = cut + 1; i < PROD_LEN; i++) name_buf[i] = blank_char();
      end
      NM_EDGES: begin
        for (i = 0; i < PROD_LEN; i++) begin
          case ($urandom_range(0, 5))
            0:       name_buf[i] = CH_SPACE;
            1:       name_buf[i] = CH_TILDE;
            2:       name_buf[i] = CH_A;
            3:       name_buf[i] = CH_Z;
            4:       name_buf[i] = CH_0;
            default: name_buf[i] = CH_9;
          endcase
        end
        name_buf[PROD_LEN - 1] = CH_Z;
      end
      default: ;
    endcase
  endtask

  // count bytes of a sector; bad_pos breaks the magic at that offset, NOISE_MAGIC makes it random
  task automatic put_sector(input int bad_pos, input int count, input bit end_it);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i < MAGIC_LEN && bad_pos != NOISE_MAGIC)
        b = (i == bad_pos) ? magic_byte(4'(i)) ^ 8'($urandom_range(1, 255)) : magic_byte(4'(i));
      if (i >= PROD_OFF && i < PROD_OFF + PROD_LEN) b = name_buf[i - PROD_OFF];
      send_byte(b, end_it && i == count - 1);
    end
  endtask

  function automatic int broken_magic();
    return ($urandom_range(0, 3) == 0) ? NOISE_MAGIC : $urandom_range(0, MAGIC_LEN - 1);
  endfunction

  function automatic name_kind_e any_name();
    return name_kind_e'($urandom_range(0, NM_EDGES));
  endfunction

  task automatic send_image(input image_shape_e shape);
    case (shape)
      IMG_SHORT: send_noise($urandom_range(1, 40));
      IMG_HEADER: begin
        repeat ($urandom_range(0, 2)) begin
          make_product(any_name());
          put_sector(broken_magic(), SECTOR_BYTES, 1'b0);
        end
        make_product(any_name());
        if ($urandom_range(0, 3) == 0) begin
          put_sector(HDR_OK, SECTOR_BYTES, 1'b1);
        end else begin
          put_sector(HDR_OK, SECTOR_BYTES, 1'b0);
          send_noise($urandom_range(1, 64));
        end
      end
      IMG_PARTIAL: begin
        make_product(any_name());
        put_sector(HDR_OK, $urandom_range(1, SECTOR_BYTES - 1), 1'b1);
      end
      default: begin
        repeat ($urandom_range(1, 2)) put_sector(broken_magic(), SECTOR_BYTES, 1'b0);
        send_noise($urandom_range(1, 16));
      end
    endcase
  endtask

  task automatic random_images(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) send_image(IMG_SHORT);
      else if (r < 8) send_image(IMG_HEADER);
      else if (r == 8) send_image(IMG_PARTIAL);
      else send_image(IMG_NO_HEADER);
      if (i == n / 2) settle();
    end
  endtask

  // stop sending and wait until every report is back and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #64_000_000;
    $display("tb_disc_header_product_id_scanner NOT OK");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte images at both byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // every product shape in a header sector, ending on or after the sector
    for (int k = 0; k <= NM_EDGES; k++) begin
      make_product(name_kind_e'(k));
      put_sector(HDR_OK, SECTOR_BYTES, k[0]);
      if (!k[0]) send_noise(3);
    end
    // header sector cut short by the image end
    make_product(NM_PLAIN);
    put_sector(HDR_OK, SECTOR_BYTES - 1, 1'b1);
    // header in the second sector
    put_sector(0, SECTOR_BYTES, 1'b0);
    make_product(NM_DIGITS);
    put_sector(HDR_OK, SECTOR_BYTES, 1'b1);
    settle();

    // limit of one sector: a header in sector 1 is never reached
    set_limit(16'd1);
    put_sector(MAGIC_LEN - 1, SECTOR_BYTES, 1'b0);
    make_product(NM_PLAIN);
    put_sector(HDR_OK, SECTOR_BYTES, 1'b0);
    send_noise(4);
    settle();

    set_limit(16'd2);
    put_sector(NOISE_MAGIC, SECTOR_BYTES, 1'b0);
    make_product(NM_EDGES);
    put_sector(HDR_OK, SECTOR_BYTES, 1'b1);
    put_sector(5, SECTOR_BYTES, 1'b0);
    put_sector(7, SECTOR_BYTES, 1'b0);
    send_noise(2);
    settle();

    // random part, one phase per limit; the first runs with no random idling
    set_limit(16'hFFFF);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_images(12);
    settle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    set_limit(16'd3);
    random_images(12);
    // long result hold-off while short images pile up behind it
    stall_asks++;
    repeat (30) send_noise($urandom_range(1, 2));
    settle();

    set_limit(16'd1);
    random_images(12);
    settle();

    set_limit(16'd2);
    random_images(12);
    settle();

    set_limit(MAX_SECTORS_RESET);
    random_images(12);
    settle();

    if (fail_count == 0) begin
      $display("tb_disc_header_product_id_scanner OK");
    end else begin
      $display("tb_disc_header_product_id_scanner NOT OK");
    end
    $finish;
  end

endmodule
